### src/htbt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// htbt_pkg
// Shared types, codes and helpers for the hex text BER-TLV splitter.
// ----------------------------------------------------------------------------
package htbt_pkg;

    // width of the running record counter (saturating)
    localparam int COUNT_BITS = 16;

    // ASCII codes used by the hex digit decoder
    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_9  = 8'h39;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UF = 8'h46;
    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LF = 8'h66;

    // low five tag bits all set: a second tag byte follows
    localparam logic [4:0] TAG_WIDE_MARK = 5'h1F;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_HEX = 2'd1,
        ST_TRUNC   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        PH_TAG1_HI = 3'd0,
        PH_TAG1_LO = 3'd1,
        PH_TAG2_HI = 3'd2,
        PH_TAG2_LO = 3'd3,
        PH_LEN_HI  = 3'd4,
        PH_LEN_LO  = 3'd5,
        PH_VAL_HI  = 3'd6,
        PH_VAL_LO  = 3'd7
    } phase_t;

    // one classified character, as queued between front and back
    typedef struct packed {
        logic [3:0] nib;
        logic       bad;
        logic       fin;
    } htbt_item_t;

    // queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic not_empty;
    } htbt_q_stat_t;

    // counter shown on the 16-bit port: zero-extended or truncated
    function automatic logic [15:0] count_out(input logic [COUNT_BITS-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        return w[15:0];
    endfunction

endpackage
`default_nettype wire

### src/htbt_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// htbt_front
// Input side: takes characters and classifies each as a hex nibble or bad.
// ----------------------------------------------------------------------------
module htbt_front
    import htbt_pkg::*;
(
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [7:0]   text_char,
    input  wire logic         is_final,
    input  wire htbt_q_stat_t q_stat,
    output logic              push,
    output htbt_item_t        item
);

    always_comb
    begin
        item.nib = 4'd0;
        item.bad = 1'b0;
        item.fin = is_final;
        if (text_char >= CH_0 && text_char <= CH_9)
        begin
            item.nib = 4'(text_char - CH_0);
        end
        else if (text_char >= CH_UA && text_char <= CH_UF)
        begin
            item.nib = 4'(text_char - CH_UA + 8'd10);
        end
        else if (text_char >= CH_LA && text_char <= CH_LF)
        begin
            item.nib = 4'(text_char - CH_LA + 8'd10);
        end
        else
        begin
            item.bad = 1'b1;
        end
    end

    assign in_ready = !q_stat.full;
    assign push     = in_valid && !q_stat.full;

endmodule
`default_nettype wire

### src/htbt_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// htbt_queue
// Two-entry queue between the classifier and the parser.
// ----------------------------------------------------------------------------
module htbt_queue
    import htbt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire htbt_item_t push_item,
    input  wire logic       pop,
    output htbt_item_t      head_item,
    output htbt_q_stat_t    q_stat
);

    htbt_item_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item        = slot_reg[rd_ptr_reg];
    assign q_stat.full      = count_reg[1];
    assign q_stat.not_empty = (count_reg != 2'd0);

endmodule
`default_nettype wire

### src/htbt_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// htbt_back
// Parser: walks the TLV phases per nibble and registers each result.
// ----------------------------------------------------------------------------
module htbt_back
    import htbt_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire htbt_q_stat_t q_stat,
    input  wire htbt_item_t   head_item,
    output logic              pop,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [15:0]       tag_value,
    output logic              tag_is_wide,
    output logic [7:0]        value_length,
    output logic [7:0]        value_byte,
    output logic              byte_valid,
    output logic              record_end,
    output logic [15:0]       record_count,
    output logic [1:0]        status,
    output logic              buffer_done
);

    phase_t                phase_reg, phase_next;
    logic [3:0]            held_reg, held_next;
    logic [15:0]           tag_reg, tag_next;
    logic                  wide_reg, wide_next;
    logic [7:0]            len_reg, len_next;
    logic [7:0]            left_reg, left_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic                  err_reg, err_next;

    logic                  ov_reg, ov_next;
    logic [15:0]           o_tag_reg, o_tag_next;
    logic                  o_wide_reg, o_wide_next;
    logic [7:0]            o_len_reg, o_len_next;
    logic [7:0]            o_vbyte_reg, o_vbyte_next;
    logic                  o_bval_reg, o_bval_next;
    logic                  o_rend_reg, o_rend_next;
    logic [15:0]           o_cnt_reg, o_cnt_next;
    status_t               o_st_reg, o_st_next;
    logic                  o_done_reg, o_done_next;

    logic                  produce;
    logic                  ended;
    logic [7:0]            byte_val;
    logic [7:0]            left_dec;

    assign pop = q_stat.not_empty && (!ov_reg || out_ready);

    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        tag_next   = tag_reg;
        wide_next  = wide_reg;
        len_next   = len_reg;
        left_next  = left_reg;
        cnt_next   = cnt_reg;
        err_next   = err_reg;

        produce      = 1'b0;
        ended        = 1'b0;
        byte_val     = {held_reg, head_item.nib};
        left_dec     = left_reg - 8'd1;
        o_vbyte_next = 8'd0;
        o_bval_next  = 1'b0;
        o_rend_next  = 1'b0;
        o_st_next    = ST_OK;
        o_done_next  = head_item.fin;

        if (pop)
        begin
            if (err_reg)
            begin
                produce   = head_item.fin;
                o_st_next = ST_BAD_HEX;
            end
            else if (head_item.bad)
            begin
                err_next  = 1'b1;
                produce   = 1'b1;
                o_st_next = ST_BAD_HEX;
            end
            else
            begin
                case (phase_reg)
                    PH_TAG1_HI, PH_TAG2_HI, PH_LEN_HI, PH_VAL_HI:
                    begin
                        held_next  = head_item.nib;
                        phase_next = phase_t'(phase_reg + 3'd1);
                    end
                    PH_TAG1_LO:
                    begin
                        tag_next   = {8'd0, byte_val};
                        wide_next  = (byte_val[4:0] == TAG_WIDE_MARK);
                        len_next   = 8'd0;
                        phase_next = (byte_val[4:0] == TAG_WIDE_MARK) ? PH_TAG2_HI
                                                                     : PH_LEN_HI;
                    end
                    PH_TAG2_LO:
                    begin
                        tag_next   = {tag_reg[7:0], byte_val};
                        phase_next = PH_LEN_HI;
                    end
                    PH_LEN_LO:
                    begin
                        len_next  = byte_val;
                        left_next = byte_val;
                        if (byte_val == 8'd0)
                        begin
                            ended = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_VAL_HI;
                        end
                    end
                    PH_VAL_LO:
                    begin
                        o_vbyte_next = byte_val;
                        o_bval_next  = 1'b1;
                        left_next    = left_dec;
                        if (left_dec == 8'd0)
                        begin
                            ended = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_VAL_HI;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_TAG1_HI;
                    end
                endcase

                if (ended)
                begin
                    phase_next = PH_TAG1_HI;
                    if (cnt_reg != {COUNT_BITS{1'b1}})
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                o_rend_next = ended;
                if (o_bval_next || ended)
                begin
                    produce = 1'b1;
                end
                else if (head_item.fin)
                begin
                    produce   = 1'b1;
                    o_st_next = ST_TRUNC;
                end
            end
        end

        // result fields show the registers as updated by this character
        o_tag_next  = tag_next;
        o_wide_next = wide_next;
        o_len_next  = len_next;
        o_cnt_next  = count_out(cnt_next);

        // end of buffer: parser returns to its reset state
        if (pop && head_item.fin)
        begin
            phase_next = PH_TAG1_HI;
            held_next  = 4'd0;
            tag_next   = 16'd0;
            wide_next  = 1'b0;
            len_next   = 8'd0;
            left_next  = 8'd0;
            cnt_next   = '0;
            err_next   = 1'b0;
        end

        if (pop && produce)
        begin
            ov_next = 1'b1;
        end
        else if (out_ready)
        begin
            ov_next = 1'b0;
        end
        else
        begin
            ov_next = ov_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TAG1_HI;
            held_reg  <= 4'd0;
            tag_reg   <= 16'd0;
            wide_reg  <= 1'b0;
            len_reg   <= 8'd0;
            left_reg  <= 8'd0;
            cnt_reg   <= '0;
            err_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            tag_reg   <= tag_next;
            wide_reg  <= wide_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
            cnt_reg   <= cnt_next;
            err_reg   <= err_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && produce)
        begin
            o_tag_reg   <= o_tag_next;
            o_wide_reg  <= o_wide_next;
            o_len_reg   <= o_len_next;
            o_vbyte_reg <= o_vbyte_next;
            o_bval_reg  <= o_bval_next;
            o_rend_reg  <= o_rend_next;
            o_cnt_reg   <= o_cnt_next;
            o_st_reg    <= o_st_next;
            o_done_reg  <= o_done_next;
        end
    end

    assign out_valid    = ov_reg;
    assign tag_value    = o_tag_reg;
    assign tag_is_wide  = o_wide_reg;
    assign value_length = o_len_reg;
    assign value_byte   = o_vbyte_reg;
    assign byte_valid   = o_bval_reg;
    assign record_end   = o_rend_reg;
    assign record_count = o_cnt_reg;
    assign status       = o_st_reg;
    assign buffer_done  = o_done_reg;

endmodule
`default_nettype wire

### src/hex_text_ber_tlv_splitter_unit.sv
`default_nettype none
// Path: an accepted character is written into the two-entry request queue; the
// parser step in the back end then registers its result (if any) in the result register.
// Throughput: one character per cycle while out_ready holds; the queue absorbs stalls.
// Output stalls hold the result register; input keeps flowing while queue has room.
// Reset (rst_n low, asynchronous): parser phase, counter, error flag, queue
// and output valid clear; result payload registers are not reset.
// ----------------------------------------------------------------------------
// hex_text_ber_tlv_splitter_unit
// Splits ASCII hex BER-TLV text into value bytes with tag, length and status.
// ----------------------------------------------------------------------------
module hex_text_ber_tlv_splitter_unit
    import htbt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // character input channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  text_char,
    input  wire logic        is_final,
    // result output channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      tag_value,
    output logic             tag_is_wide,
    output logic [7:0]       value_length,
    output logic [7:0]       value_byte,
    output logic             byte_valid,
    output logic             record_end,
    output logic [15:0]      record_count,
    output logic [1:0]       status,
    output logic             buffer_done
);

    // front -> queue: classified request (nibble, bad-digit flag, final flag)
    htbt_item_t   push_item;
    logic         push;
    // queue -> back: head request and occupancy
    htbt_item_t   head_item;
    htbt_q_stat_t q_stat;
    logic         pop;

    // Front: hex digit decode, accepts whenever the queue has room.
    htbt_front u_front (
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .text_char (text_char),
        .is_final  (is_final),
        .q_stat    (q_stat),
        .push      (push),
        .item      (push_item)
    );

    // Queue: lets front and back stall independently.
    htbt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .q_stat    (q_stat)
    );

    // Back: TLV phase machine; pops when the result register is free
    // or being drained in the same cycle.
    htbt_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_stat       (q_stat),
        .head_item    (head_item),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .tag_value    (tag_value),
        .tag_is_wide  (tag_is_wide),
        .value_length (value_length),
        .value_byte   (value_byte),
        .byte_valid   (byte_valid),
        .record_end   (record_end),
        .record_count (record_count),
        .status       (status),
        .buffer_done  (buffer_done)
    );

endmodule
`default_nettype wire

### src/htbt_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// htbt_checker
// Port-level checks on the splitter's result channel.
// ----------------------------------------------------------------------------
module htbt_checker
    import htbt_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [7:0]  value_byte,
    input wire logic        byte_valid,
    input wire logic        record_end,
    input wire logic [1:0]  status,
    input wire logic        buffer_done
);

    // a stalled result stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // data and record ends only on good results
    a_ok_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (byte_valid || record_end) |-> status == ST_OK)
        else $error("data result with error status");

    // truncation is reported only at buffer end
    a_trunc_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_TRUNC |-> buffer_done && !byte_valid && !record_end)
        else $error("truncated status off buffer end");

    // no byte, zero value
    a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> value_byte == 8'd0)
        else $error("value_byte nonzero without byte_valid");

endmodule

bind hex_text_ber_tlv_splitter_unit htbt_checker u_htbt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .value_byte  (value_byte),
    .byte_valid  (byte_valid),
    .record_end  (record_end),
    .status      (status),
    .buffer_done (buffer_done)
);
`default_nettype wire
